/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the allocator core.
// BPA_ASSERT:      a property checked at every rising clock edge out of reset.
// BPA_ASSERT_NEXT: a condition that must hold one cycle after a trigger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define BPA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define BPA_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) else $error(msg);

`else

`define BPA_ASSERT(lbl, clk, rstn, prop, msg)

`define BPA_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg)

`endif

`endif

/* rtl/core/bpa_pkg.sv */
`default_nettype none

package bpa_pkg;

  // default pool size in pages
  localparam int POOL_PAGES_DEF = 1024;

  // field widths
  localparam int ACT_W    = 2;
  localparam int REQ_W    = 11;
  localparam int PAGE_W   = 10;
  localparam int STS_W    = 2;
  localparam int BOFF_W   = 10;
  localparam int BPAGES_W = 11;
  localparam int LFREE_W  = 11;

  // input beat layout
  localparam int IN_ACT_LSB  = 0;
  localparam int IN_REQ_LSB  = IN_ACT_LSB + ACT_W;
  localparam int IN_PAGE_LSB = IN_REQ_LSB + REQ_W;
  localparam int IN_TDATA_W  = 24;

  // output beat layout
  localparam int OUT_STS_LSB    = 0;
  localparam int OUT_BOFF_LSB   = OUT_STS_LSB + STS_W;
  localparam int OUT_BPAGES_LSB = OUT_BOFF_LSB + BOFF_W;
  localparam int OUT_LFREE_LSB  = OUT_BPAGES_LSB + BPAGES_W;
  localparam int OUT_TDATA_W    = 40;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_NO_FIT   = 2'd1,
    STS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_DOWN,
    ST_CLIMB,
    ST_UP,
    ST_RESULT
  } ctl_state_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INIT,
    OP_LOAD,
    OP_START,
    OP_DOWN,
    OP_CLIMB,
    OP_UP
  } dp_op_e;

  // controller -> datapath
  typedef struct packed {
    dp_op_e op;
    logic   res_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_done;
    logic go_down;
    logic go_climb;
    logic step_up;
    logic step_done;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/bpa_ram.sv */
`default_nettype none

// Simple dual read, single write RAM with registered read data.
module bpa_ram #(
  parameter int WIDTH = bpa_pkg::BPAGES_W,
  parameter int DEPTH = 2 * bpa_pkg::POOL_PAGES_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

/* rtl/core/bpa_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"

// Sequencer: init sweep, request decode, tree walk, result handoff.
module bpa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  input  wire bpa_pkg::dp_sts_t  sts_i,
  output bpa_pkg::dp_cmd_t       cmd_o
);

  import bpa_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sts_i.init_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts_i.go_down) state_d = ST_DOWN;
        else if (sts_i.go_climb) state_d = ST_CLIMB;
        else state_d = ST_RESULT;
      end
      ST_DOWN, ST_CLIMB: begin
        if (sts_i.step_done) state_d = ST_RESULT;
        else if (sts_i.step_up) state_d = ST_UP;
      end
      ST_UP: begin
        if (sts_i.step_done) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || m_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = OP_NOP;
    cmd_o.res_load = 1'b0;
    case (state_q)
      ST_INIT:   cmd_o.op = OP_INIT;
      ST_IDLE:   cmd_o.op = s_valid_i ? OP_LOAD : OP_NOP;
      ST_DECODE: cmd_o.op = OP_START;
      ST_DOWN:   cmd_o.op = OP_DOWN;
      ST_CLIMB:  cmd_o.op = OP_CLIMB;
      ST_UP:     cmd_o.op = OP_UP;
      ST_RESULT: cmd_o.res_load = !out_valid_q || m_ready_i;
      default:   cmd_o.op = OP_NOP;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) out_valid_d = 1'b1;
    else if (m_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `BPA_ASSERT(a_load_free, clk_i, rst_ni, !cmd_o.res_load || !out_valid_q || m_ready_i, "result overwrote pending beat")
  `BPA_ASSERT_NEXT(a_accept_decode, clk_i, rst_ni, accept, state_q == ST_DECODE, "accepted beat not decoded")
  `BPA_ASSERT(a_valid_src, clk_i, rst_ni, !$rose(out_valid_q) || $past(state_q == ST_RESULT), "output valid without result")

endmodule

`default_nettype wire

/* rtl/core/bpa_dp.sv */
`default_nettype none
`include "assert_macros.svh"

// Tree datapath: node memory, walk registers, result and output registers.
module bpa_dp #(
  parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire bpa_pkg::dp_cmd_t                  cmd_i,
  output bpa_pkg::dp_sts_t                       sts_o,
  input  wire logic [bpa_pkg::IN_TDATA_W-1:0]    in_tdata_i,
  output logic      [bpa_pkg::OUT_TDATA_W-1:0]   out_tdata_o
);

  import bpa_pkg::*;

  // tree geometry
  localparam int LVL    = $clog2(POOL_PAGES + 1) - 1;
  localparam int LEAVES = 2 ** LVL;
  localparam int AW     = LVL;
  localparam int NW     = LVL + 1;
  localparam int VW     = LVL + 1;
  localparam int CW     = (REQ_W > VW) ? REQ_W : VW;
  localparam int EW     = (PAGE_W > NW) ? PAGE_W : NW;
  localparam int DEPTH  = 2 * LEAVES;

  // memory ports
  logic          ram_we;
  logic [NW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [VW-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

  // control registers
  logic [NW-1:0] init_q, init_d;
  logic [VW-1:0] isize_q, isize_d;
  logic [VW-1:0] root_q, root_d;

  // walk and request registers
  action_e       act_q;
  logic [REQ_W-1:0] want_q;
  logic [AW-1:0] page_q;
  logic          page_bad_q;
  logic [NW-1:0] node_q, node_d;
  logic [VW-1:0] size_q, size_d;
  logic [AW-1:0] off_q, off_d;
  logic [VW-1:0] cur_q, cur_d;
  status_e       res_sts_q, res_sts_d;
  logic [AW-1:0] res_boff_q, res_boff_d;
  logic [VW-1:0] res_bpages_q, res_bpages_d;
  logic [OUT_TDATA_W-1:0] out_q, out_d;

  // helper terms
  logic [REQ_W-1:0]  in_req;
  logic [PAGE_W-1:0] in_page;
  logic [NW-1:0]     child_l, child_r, tgt, leaf_node, parent;
  logic [VW-1:0]     half, tsize, psize, upd_val, max_val;
  logic [AW-1:0]     toff, free_boff;
  logic              go_l, go_r, at_end;
  logic [VW:0]       sum;

  bpa_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  assign in_req  = in_tdata_i[IN_REQ_LSB +: REQ_W];
  assign in_page = in_tdata_i[IN_PAGE_LSB +: PAGE_W];

  // descent: pick the left child, else the right, else stop here
  assign child_l = {node_q[NW-2:0], 1'b0};
  assign child_r = {node_q[NW-2:0], 1'b1};
  assign half    = size_q >> 1;
  assign go_l    = CW'(ram_rdata_a) >= CW'(want_q);
  assign go_r    = CW'(ram_rdata_b) >= CW'(want_q);
  assign tgt     = go_l ? child_l : (go_r ? child_r : node_q);
  assign tsize   = (go_l || go_r) ? half : size_q;
  assign toff    = (!go_l && go_r) ? off_q + AW'(half) : off_q;
  assign at_end  = !(go_l || go_r) || tgt[NW-1];

  // climb and merge
  assign leaf_node = NW'(LEAVES) | NW'(page_q);
  assign free_boff = page_q & ~AW'(size_q - 1'b1);
  assign parent    = node_q >> 1;
  assign psize     = size_q << 1;
  assign sum       = {1'b0, cur_q} + {1'b0, ram_rdata_a};
  assign max_val   = (cur_q > ram_rdata_a) ? cur_q : ram_rdata_a;
  assign upd_val   = ((act_q == ACT_FREE) && (sum == {1'b0, psize})) ? psize : max_val;

  // per-operation datapath behavior
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr_a  = '0;
    ram_raddr_b  = '0;
    init_d       = init_q;
    isize_d      = isize_q;
    root_d       = root_q;
    node_d       = node_q;
    size_d       = size_q;
    off_d        = off_q;
    cur_d        = cur_q;
    res_sts_d    = res_sts_q;
    res_boff_d   = res_boff_q;
    res_bpages_d = res_bpages_q;
    sts_o        = '0;
    sts_o.init_done = &init_q;
    case (cmd_i.op)
      // reset sweep: node at depth d holds LEAVES >> d
      OP_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_q;
        ram_wdata = isize_q;
        init_d    = init_q + 1'b1;
        if ((init_d & (init_d - 1'b1)) == '0) isize_d = isize_q >> 1;
      end
      OP_START: begin
        res_sts_d    = STS_OK;
        res_boff_d   = '0;
        res_bpages_d = '0;
        case (act_q)
          ACT_ALLOC: begin
            if (CW'(want_q) > CW'(root_q)) begin
              res_sts_d = STS_NO_FIT;
            end else begin
              ram_raddr_a   = NW'(2);
              ram_raddr_b   = NW'(3);
              node_d        = NW'(1);
              size_d        = VW'(LEAVES);
              off_d         = '0;
              sts_o.go_down = 1'b1;
            end
          end
          ACT_FREE: begin
            if (page_bad_q) begin
              res_sts_d = STS_BAD_FREE;
            end else begin
              ram_raddr_a    = leaf_node;
              node_d         = leaf_node;
              size_d         = VW'(1);
              sts_o.go_climb = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_DOWN: begin
        if (!at_end) begin
          ram_raddr_a = {tgt[NW-2:0], 1'b0};
          ram_raddr_b = {tgt[NW-2:0], 1'b1};
          node_d      = tgt;
          size_d      = tsize;
          off_d       = toff;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = tgt;
          ram_wdata    = '0;
          res_boff_d   = toff;
          res_bpages_d = tsize;
          if (tgt == NW'(1)) begin
            root_d          = '0;
            sts_o.step_done = 1'b1;
          end else begin
            ram_raddr_a   = tgt ^ NW'(1);
            node_d        = tgt;
            size_d        = tsize;
            cur_d         = '0;
            sts_o.step_up = 1'b1;
          end
        end
      end
      OP_CLIMB: begin
        if (ram_rdata_a == '0) begin
          // used node found: make it whole
          ram_we       = 1'b1;
          ram_waddr    = node_q;
          ram_wdata    = size_q;
          res_boff_d   = free_boff;
          res_bpages_d = size_q;
          if (node_q == NW'(1)) begin
            root_d          = size_q;
            sts_o.step_done = 1'b1;
          end else begin
            ram_raddr_a   = node_q ^ NW'(1);
            cur_d         = size_q;
            sts_o.step_up = 1'b1;
          end
        end else if (node_q == NW'(1)) begin
          res_sts_d       = STS_BAD_FREE;
          sts_o.step_done = 1'b1;
        end else begin
          ram_raddr_a = parent;
          node_d      = parent;
          size_d      = psize;
        end
      end
      OP_UP: begin
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = upd_val;
        if (parent == NW'(1)) begin
          root_d          = upd_val;
          sts_o.step_done = 1'b1;
        end else begin
          ram_raddr_a = parent ^ NW'(1);
          node_d      = parent;
          size_d      = psize;
          cur_d       = upd_val;
        end
      end
      default: ;
    endcase
  end

  // output beat packing
  always_comb begin
    out_d = '0;
    out_d[OUT_STS_LSB +: STS_W]       = res_sts_q;
    out_d[OUT_BOFF_LSB +: BOFF_W]     = BOFF_W'(res_boff_q);
    out_d[OUT_BPAGES_LSB +: BPAGES_W] = BPAGES_W'(res_bpages_q);
    out_d[OUT_LFREE_LSB +: LFREE_W]   = LFREE_W'(root_q);
  end

  assign out_tdata_o = out_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= NW'(1);
      isize_q <= VW'(LEAVES);
      root_q  <= VW'(LEAVES);
    end else begin
      init_q  <= init_d;
      isize_q <= isize_d;
      root_q  <= root_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      act_q      <= action_e'(in_tdata_i[IN_ACT_LSB +: ACT_W]);
      want_q     <= (in_req == '0) ? REQ_W'(1) : in_req;
      page_q     <= AW'(in_page);
      page_bad_q <= EW'(in_page) >= EW'(LEAVES);
    end
    node_q       <= node_d;
    size_q       <= size_d;
    off_q        <= off_d;
    cur_q        <= cur_d;
    res_sts_q    <= res_sts_d;
    res_boff_q   <= res_boff_d;
    res_bpages_q <= res_bpages_d;
    if (cmd_i.res_load) out_q <= out_d;
  end

  `BPA_ASSERT(a_no_node0, clk_i, rst_ni, !ram_we || (ram_waddr != '0), "write to unused node zero")
  `BPA_ASSERT(a_rw_apart, clk_i, rst_ni, !ram_we || ((ram_waddr != ram_raddr_a) && (ram_waddr != ram_raddr_b)), "read and write hit one node")
  `BPA_ASSERT(a_root_max, clk_i, rst_ni, root_q <= VW'(LEAVES), "root above pool size")

endmodule

`default_nettype wire

/* rtl/core/buddy_page_allocator_core.sv */
// Channel  | Dir | Beat fields (low bit first)
// s_axis   | in  | action[1:0], request_pages[12:2], page_offset[22:13]
// m_axis   | out | status[1:0], block_offset[11:2], block_pages[22:12], largest_free[33:23]
//
// One request at a time. The walk costs one node memory access per tree level, down and
// then up (a free: up only). After reset a sweep writes every tree node while s_axis_tready
// is low. A new request is taken while the previous result waits in the output register.
`default_nettype none

module buddy_page_allocator_core #(
  parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // action, request_pages, page_offset
  input  wire logic [bpa_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // status, block_offset, block_pages, largest_free
  output logic      [bpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  import bpa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bpa_dp #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_tdata_i  (s_axis_tdata_i),
    .out_tdata_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
